// ----- rtl/periodic_decimal_report_formatter_core_macros.svh -----
// Assertion helpers shared by the formatter modules.
// Each expects clk_i and rst_ni in the enclosing module.
`ifndef PERIODIC_DECIMAL_REPORT_FORMATTER_CORE_MACROS_SVH
`define PERIODIC_DECIMAL_REPORT_FORMATTER_CORE_MACROS_SVH

// same-cycle implication
`define PDRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdrf assertion failed");

// next-cycle implication
`define PDRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdrf assertion failed");

`endif

// ----- rtl/pdrf_pkg.sv -----
`default_nettype none
package pdrf_pkg;

  localparam int unsigned VALUE_BITS = 11;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned TickW      = 16;
  localparam int unsigned ProdW      = 14;  // holds 9 * 1000
  localparam int unsigned PosW       = 3;

  localparam logic [TickW-1:0] PeriodReset = TickW'(2000);

  localparam logic [ByteW-1:0] AsciiZero   = 8'h30;
  localparam logic [ByteW-1:0] AsciiCr     = 8'h0D;
  localparam logic [ByteW-1:0] AsciiLf     = 8'h0A;
  localparam logic [ByteW-1:0] AsciiDollar = 8'h24;
  localparam logic [ByteW-1:0] AsciiHash   = 8'h23;

  // byte positions within a report
  localparam logic [PosW-1:0] PosFirst = 3'd0;
  localparam logic [PosW-1:0] PosCr    = 3'd4;
  localparam logic [PosW-1:0] PosLf    = 3'd5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpSample = 2'd1,
    OpRx     = 2'd2
  } op_e;

  typedef struct packed {
    logic                  is_report;
    logic [VALUE_BITS-1:0] value;
    logic [ByteW-1:0]      echo_byte;
    logic                  pwm;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [3:0]       digit;
    logic [ProdW-1:0] sub;
  } digit_sel_t;

  localparam logic [ProdW-1:0] Places [4] = '{
    ProdW'(1000), ProdW'(100), ProdW'(10), ProdW'(1)
  };

  // Largest k in 0..9 with k*place <= rem; compares are independent.
  function automatic digit_sel_t digit_sel(input logic [VALUE_BITS-1:0] rem,
                                           input logic [1:0] place_idx);
    digit_sel_t       r;
    logic [ProdW-1:0] place;
    logic [ProdW-1:0] wide;
    logic [ProdW-1:0] step;
    r.digit = '0;
    r.sub   = '0;
    place   = Places[place_idx];
    wide    = ProdW'(rem);
    for (int k = 1; k <= 9; k++) begin
      step = ProdW'(ProdW'(k) * place);
      if (wide >= step) begin
        r.digit = 4'(k);
        r.sub   = step;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/periodic_decimal_report_formatter_core.sv -----
`default_nettype none
// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   opcode_i, sample_value_i, rx_byte_i
// out       out_valid_o / out_stall_i tx_byte_o, last_byte_o, pwm_enable_o
// cfg       cfg_valid_i / cfg_ready_o report_period_i
//
// One input item is taken per cycle; the front stalls only while the
// four-entry request queue is full. The byte emitter sends one byte per
// cycle unless out_stall_i holds it: six for a report, one for an echo;
// the first byte is registered off the queue head. Asynchronous active-low
// reset clears counters, flag and queue and restores a period of 2000 ticks.
module periodic_decimal_report_formatter_core import pdrf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [SampleW-1:0] sample_value_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [TickW-1:0]   report_period_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ByteW-1:0]        tx_byte_o,
  output logic                    last_byte_o,
  output logic                    pwm_enable_o
);

  queue_status_t status;
  logic          push;
  logic          pop;
  cmd_t          cmd;
  cmd_t          head;

  pdrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .sample_value_i (sample_value_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .report_period_i(report_period_i),
    .status_i       (status),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  pdrf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(status)
  );

  pdrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o),
    .pwm_enable_o(pwm_enable_o)
  );

endmodule
`default_nettype wire

// ----- rtl/pdrf_front.sv -----
`default_nettype none
module pdrf_front import pdrf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          opcode_i,
  input  wire logic [SampleW-1:0]  sample_value_i,
  input  wire logic [ByteW-1:0]    rx_byte_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [TickW-1:0]    report_period_i,
  input  wire queue_status_t       status_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  logic [TickW-1:0]      period_q;
  logic [TickW-1:0]      tick_q, tick_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  pwm_q, pwm_d;
  logic [TickW-1:0]      tick_inc;
  logic                  accept;
  op_e                   op;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = status_i.full;
  assign accept      = in_valid_i && !status_i.full;
  assign op          = op_e'(opcode_i);
  assign tick_inc    = tick_q + TickW'(1);

  always_comb begin
    tick_d          = tick_q;
    value_d         = value_q;
    pwm_d           = pwm_q;
    push_o          = 1'b0;
    cmd_o.is_report = 1'b0;
    cmd_o.value     = value_q;
    cmd_o.echo_byte = rx_byte_i;
    cmd_o.pwm       = pwm_q;
    if (accept) begin
      unique case (op)
        OpTick: begin
          if (tick_inc == period_q) begin
            tick_d          = '0;
            push_o          = 1'b1;
            cmd_o.is_report = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        OpSample: begin
          value_d = VALUE_BITS'(sample_value_i);
        end
        OpRx: begin
          if (rx_byte_i == AsciiDollar) begin
            pwm_d     = 1'b1;
            push_o    = 1'b1;
            cmd_o.pwm = 1'b1;
          end else if (rx_byte_i == AsciiHash) begin
            pwm_d     = 1'b0;
            push_o    = 1'b1;
            cmd_o.pwm = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      tick_q   <= '0;
      value_q  <= '0;
      pwm_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= report_period_i;
      end
      tick_q  <= tick_d;
      value_q <= value_d;
      pwm_q   <= pwm_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pdrf_fifo.sv -----
`default_nettype none
`include "periodic_decimal_report_formatter_core_macros.svh"
module pdrf_fifo import pdrf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire cmd_t    cmd_i,
  input  wire logic    pop_i,
  output cmd_t         head_o,
  output queue_status_t status_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  `PDRF_ASSERT_IMP(a_no_pop_empty, pop_i, !status_o.empty)
  `PDRF_ASSERT_IMP(a_no_push_full, push_i, !status_o.full)
  `PDRF_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + QueueCntW'(1))

endmodule
`default_nettype wire

// ----- rtl/pdrf_back.sv -----
`default_nettype none
`include "periodic_decimal_report_formatter_core_macros.svh"
module pdrf_back import pdrf_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cmd_t          head_i,
  input  wire queue_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [ByteW-1:0]   tx_byte_o,
  output logic               last_byte_o,
  output logic               pwm_enable_o
);

  logic                  busy_q, busy_d;
  logic [PosW-1:0]       pos_q;
  logic [VALUE_BITS-1:0] rem_q;
  cmd_t                  cmd_q;
  logic                  out_valid_q;
  logic [ByteW-1:0]      tx_q, tx_d;
  logic                  last_q, last_d;
  logic                  pwm_q;

  cmd_t                  cur_cmd;
  logic [PosW-1:0]       cur_pos;
  logic [VALUE_BITS-1:0] cur_rem;
  digit_sel_t            dsel;
  logic                  advance;
  logic                  emit;

  // Current job: a report in progress, else the queue head (first byte).
  assign cur_cmd = busy_q ? cmd_q : head_i;
  assign cur_pos = busy_q ? pos_q : PosFirst;
  assign cur_rem = busy_q ? rem_q : head_i.value;
  assign dsel    = digit_sel(cur_rem, cur_pos[1:0]);
  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && (busy_q || !status_i.empty);
  assign pop_o   = emit && !busy_q;

  always_comb begin
    tx_d   = cur_cmd.echo_byte;
    last_d = 1'b1;
    busy_d = busy_q;
    if (cur_cmd.is_report) begin
      last_d = 1'b0;
      unique case (cur_pos)
        PosCr: tx_d = AsciiCr;
        PosLf: begin
          tx_d   = AsciiLf;
          last_d = 1'b1;
        end
        default: tx_d = AsciiZero + ByteW'(dsel.digit);
      endcase
    end
    if (emit) begin
      busy_d = !last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cmd_q <= cur_cmd;
      pos_q <= cur_pos + PosW'(1);
      rem_q <= cur_rem - dsel.sub[VALUE_BITS-1:0];
      tx_q  <= tx_d;
      last_q <= last_d;
      pwm_q <= cur_cmd.pwm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_q;
  assign last_byte_o  = last_q;
  assign pwm_enable_o = pwm_q;

  // only reports span several bytes, and never past the LF
  `PDRF_ASSERT_IMP(a_busy_report, busy_q, cmd_q.is_report && pos_q != PosFirst && pos_q <= PosLf)
  `PDRF_ASSERT_NEXT(a_hold_busy, busy_q && !emit, busy_q && $stable(pos_q))

endmodule
`default_nettype wire
